/* rtl/pcsc_pkg.sv */
package pcsc_pkg;

  typedef struct packed {
    logic [15:0] primary_in;
    logic [7:0]  second_in;
    logic [7:0]  third_in;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] primary_out;
    logic [7:0]  second_out;
    logic [7:0]  third_out;
  } pix_out_t;

  // conversion_mode codes
  localparam logic [3:0] MODE_RGB_TO_565  = 4'd0;
  localparam logic [3:0] MODE_565_TO_RGB  = 4'd1;
  localparam logic [3:0] MODE_RGB_TO_GREY = 4'd2;
  localparam logic [3:0] MODE_GREY_TO_RGB = 4'd3;
  localparam logic [3:0] MODE_565_TO_GREY = 4'd4;
  localparam logic [3:0] MODE_GREY_TO_565 = 4'd5;
  localparam logic [3:0] MODE_RGB_TO_HSV  = 4'd6;
  localparam logic [3:0] MODE_HSV_TO_RGB  = 4'd7;
  localparam logic [3:0] MODE_565_TO_HSV  = 4'd8;
  localparam logic [3:0] MODE_HSV_TO_565  = 4'd9;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [8:0] h;
    logic [7:0] s;
    logic [7:0] v;
  } hsv_t;

endpackage

/* rtl/pcsc_rgb2hsv.sv */
module pcsc_rgb2hsv (
  input  logic          clk,
  input  pcsc_pkg::rgb_t pix,
  output pcsc_pkg::hsv_t hsv
);

  localparam logic [1:0] MAX_R = 2'd0;
  localparam logic [1:0] MAX_G = 2'd1;
  localparam logic [1:0] MAX_B = 2'd2;
  localparam int DIV_STAGES = 4;

  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] nlo;
    logic [7:0] q;
  } div_t;

  typedef struct packed {
    logic [7:0] mx;
    logic [7:0] delta;
    logic       neg;
    logic [1:0] sel;
  } side_t;

  // one restoring division step; remainder stays below the divisor
  function automatic div_t div_step(div_t x, logic [7:0] d);
    logic [8:0] t;
    logic       ge;
    div_t       y;
    t = {x.rem, x.nlo[7]};
    ge = (t >= {1'b0, d});
    y.rem = ge ? 8'(t - {1'b0, d}) : t[7:0];
    y.nlo = {x.nlo[6:0], 1'b0};
    y.q = {x.q[6:0], ge};
    return y;
  endfunction

  // stage 1 comb
  logic [7:0] mx_c, mn_c, hi_c, lo_c;
  logic [1:0] sel_c;

  side_t      sd [DIV_STAGES + 2];
  logic [7:0] absd;
  logic [15:0] nsat, nhue;
  div_t       ls [DIV_STAGES];
  div_t       lh [DIV_STAGES];
  div_t       ls0, lh0;

  always_comb begin
    if (pix.r >= pix.g && pix.r >= pix.b) begin
      sel_c = MAX_R;
      mx_c = pix.r;
      hi_c = pix.g;
      lo_c = pix.b;
    end else if (pix.g >= pix.b) begin
      sel_c = MAX_G;
      mx_c = pix.g;
      hi_c = pix.b;
      lo_c = pix.r;
    end else begin
      sel_c = MAX_B;
      mx_c = pix.b;
      hi_c = pix.r;
      lo_c = pix.g;
    end
    mn_c = pix.r;
    if (pix.g < mn_c) mn_c = pix.g;
    if (pix.b < mn_c) mn_c = pix.b;
  end

  always_comb begin
    ls0 = div_step(div_step('{rem: nsat[15:8], nlo: nsat[7:0], q: 8'd0}, sd[1].mx),
                   sd[1].mx);
    lh0 = div_step(div_step('{rem: nhue[15:8], nlo: nhue[7:0], q: 8'd0}, sd[1].delta),
                   sd[1].delta);
  end

  always_ff @(posedge clk) begin
    sd[0].mx <= mx_c;
    sd[0].delta <= mx_c - mn_c;
    sd[0].neg <= (hi_c < lo_c);
    sd[0].sel <= sel_c;
    absd <= (hi_c < lo_c) ? lo_c - hi_c : hi_c - lo_c;
    // numerators: 255*delta and 60*|diff|
    sd[1] <= sd[0];
    nsat <= {sd[0].delta, 8'd0} - {8'd0, sd[0].delta};
    nhue <= 16'({8'd0, absd} * 16'd60);
    // two quotient bits per stage
    ls[0] <= ls0;
    lh[0] <= lh0;
    sd[2] <= sd[1];
    for (int k = 1; k < DIV_STAGES; k++) begin
      ls[k] <= div_step(div_step(ls[k-1], sd[k+1].mx), sd[k+1].mx);
      lh[k] <= div_step(div_step(lh[k-1], sd[k+1].delta), sd[k+1].delta);
      sd[k+2] <= sd[k+1];
    end
  end

  logic signed [9:0] base, hue;
  logic signed [9:0] qx;

  always_comb begin
    case (sd[DIV_STAGES+1].sel)
      MAX_R:   base = 10'sd0;
      MAX_G:   base = 10'sd120;
      default: base = 10'sd240;
    endcase
    qx = $signed({2'b00, lh[DIV_STAGES-1].q});
    hue = sd[DIV_STAGES+1].neg ? base - qx : base + qx;
    if (hue < 0) hue = hue + 10'sd360;
  end

  always_ff @(posedge clk) begin
    hsv.v <= sd[DIV_STAGES+1].mx;
    if (sd[DIV_STAGES+1].delta == 8'd0) begin
      hsv.h <= 9'd0;
      hsv.s <= 8'd0;
    end else begin
      hsv.h <= hue[8:0];
      hsv.s <= ls[DIV_STAGES-1].q;
    end
  end

endmodule

/* rtl/pcsc_hsv2rgb.sv */
module pcsc_hsv2rgb (
  input  logic          clk,
  input  logic [15:0]   hue,
  input  logic [7:0]    sat,
  input  logic [7:0]    val,
  output pcsc_pkg::rgb_t rgb
);

  localparam logic [2:0] SECT_0 = 3'd0;
  localparam logic [2:0] SECT_1 = 3'd1;
  localparam logic [2:0] SECT_2 = 3'd2;
  localparam logic [2:0] SECT_3 = 3'd3;
  localparam logic [2:0] SECT_4 = 3'd4;
  localparam logic [2:0] SECT_5 = 3'd5;

  typedef struct packed {
    logic       s_zero;
    logic [2:0] sector;
    logic [7:0] v;
  } side_t;

  // stage 1: quotient estimate of hue/360, low by at most one
  logic [15:0] h1;
  logic [7:0]  s1, v1, qe1;
  logic [30:0] prod1;

  assign prod1 = {15'd0, hue} * 31'd23301;

  always_ff @(posedge clk) begin
    h1 <= hue;
    s1 <= sat;
    v1 <= val;
    qe1 <= prod1[30:23];
  end

  // stage 2: hue mod 360
  logic [16:0] m360;
  logic [9:0]  hm0;
  logic [8:0]  hm2;
  logic [7:0]  s2, v2;

  assign m360 = {9'd0, qe1} * 17'd360;
  assign hm0 = 10'({1'b0, h1} - m360);

  always_ff @(posedge clk) begin
    hm2 <= (hm0 >= 10'd360) ? 9'(hm0 - 10'd360) : hm0[8:0];
    s2 <= s1;
    v2 <= v1;
  end

  // stage 3: sector and rem = (h % 60) * 17 / 4
  logic [2:0] sect_c;
  logic [8:0] off_c;
  logic [5:0] hr_c;
  logic [9:0] r17_c;
  logic [2:0] sect3;
  logic [7:0] rem3, s3, v3;

  always_comb begin
    if (hm2 >= 9'd300) begin
      sect_c = SECT_5;
      off_c = 9'd300;
    end else if (hm2 >= 9'd240) begin
      sect_c = SECT_4;
      off_c = 9'd240;
    end else if (hm2 >= 9'd180) begin
      sect_c = SECT_3;
      off_c = 9'd180;
    end else if (hm2 >= 9'd120) begin
      sect_c = SECT_2;
      off_c = 9'd120;
    end else if (hm2 >= 9'd60) begin
      sect_c = SECT_1;
      off_c = 9'd60;
    end else begin
      sect_c = SECT_0;
      off_c = 9'd0;
    end
    hr_c = 6'(hm2 - off_c);
    r17_c = {hr_c, 4'd0} + {4'd0, hr_c};
  end

  always_ff @(posedge clk) begin
    sect3 <= sect_c;
    rem3 <= r17_c[9:2];
    s3 <= s2;
    v3 <= v2;
  end

  // stage 4: 8x8 products
  side_t       sd4, sd5, sd6;
  logic [15:0] pn4, e1_4, e2_4;

  always_ff @(posedge clk) begin
    sd4.s_zero <= (s3 == 8'd0);
    sd4.sector <= sect3;
    sd4.v <= v3;
    pn4 <= {8'd0, v3} * {8'd0, 8'd255 - s3};
    e1_4 <= 16'd65025 - {8'd0, s3} * {8'd0, rem3};
    e2_4 <= 16'd65025 - {8'd0, s3} * {8'd0, 8'd255 - rem3};
  end

  // stage 5: p = pn/255 exactly for pn below 65535; v*e products
  logic [16:0] x255;
  logic [7:0]  p5;
  logic [23:0] yq5, yt5;

  assign x255 = {1'b0, pn4} + 17'd1 + {9'd0, pn4[15:8]};

  always_ff @(posedge clk) begin
    sd5 <= sd4;
    p5 <= x255[15:8];
    yq5 <= {16'd0, sd4.v} * {8'd0, e1_4};
    yt5 <= {16'd0, sd4.v} * {8'd0, e2_4};
  end

  // stage 6: reciprocal estimate of y/65025, low by at most one
  logic [40:0] pq6, pt6;
  logic [7:0]  p6, q0q6, q0t6;
  logic [23:0] yq6, yt6;

  assign pq6 = {17'd0, yq5} * 41'd66051;
  assign pt6 = {17'd0, yt5} * 41'd66051;

  always_ff @(posedge clk) begin
    sd6 <= sd5;
    p6 <= p5;
    yq6 <= yq5;
    yt6 <= yt5;
    q0q6 <= pq6[39:32];
    q0t6 <= pt6[39:32];
  end

  // stage 7: correction and sector select
  logic [23:0] rq, rt;
  logic [7:0]  qv, tv;

  always_comb begin
    rq = yq6 - {16'd0, q0q6} * 24'd65025;
    rt = yt6 - {16'd0, q0t6} * 24'd65025;
    qv = (rq >= 24'd65025) ? q0q6 + 8'd1 : q0q6;
    tv = (rt >= 24'd65025) ? q0t6 + 8'd1 : q0t6;
  end

  always_ff @(posedge clk) begin
    if (sd6.s_zero) begin
      rgb <= {sd6.v, sd6.v, sd6.v};
    end else begin
      case (sd6.sector)
        SECT_0:  rgb <= {sd6.v, tv, p6};
        SECT_1:  rgb <= {qv, sd6.v, p6};
        SECT_2:  rgb <= {p6, sd6.v, tv};
        SECT_3:  rgb <= {p6, qv, sd6.v};
        SECT_4:  rgb <= {tv, p6, sd6.v};
        default: rgb <= {sd6.v, p6, qv};
      endcase
    end
  end

endmodule

/* rtl/pixel_color_space_converter.sv */
// Channel  Ports                    Handshake
// -------  -----------------------  -----------------------------------------
// pixel    pixel, start, busy       item taken when start && !busy
// result   result, done             done high one cycle per item, no backpressure
// config   cfg_we, cfg_data         conversion_mode written when cfg_we
//
// One item per clock; busy never rises. Each taken item passes the input
// register, seven stages set by the 8-step restoring divider (RGB to HSV)
// and the multiply/reciprocal chain (HSV to RGB), then the output register.
// Synchronous reset clears valid bits and the mode register; the pipeline
// drains nothing after reset.
module pixel_color_space_converter (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  pcsc_pkg::pix_in_t  pixel,
  output logic               done,
  output pcsc_pkg::pix_out_t result,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data
);

  localparam int DEPTH = 7;

  typedef struct packed {
    logic [3:0]     mode;
    pcsc_pkg::rgb_t src;
    logic [17:0]    lsum;
  } stage_t;

  function automatic logic [15:0] pack565(pcsc_pkg::rgb_t c);
    return {c.r[7:3], c.g[7:2], c.b[7:3]};
  endfunction

  logic [3:0]         conversion_mode;
  logic               s1_valid;
  pcsc_pkg::pix_in_t  s1_pix;
  logic [DEPTH-1:0]   vld;
  stage_t             line [DEPTH];
  pcsc_pkg::rgb_t     src;
  logic [17:0]        lsum;
  pcsc_pkg::hsv_t     hsv_res;
  pcsc_pkg::rgb_t     rgb_res;
  pcsc_pkg::pix_out_t res_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      conversion_mode <= pcsc_pkg::MODE_RGB_TO_565;
    end else if (cfg_we) begin
      conversion_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_pix <= pixel;
  end

  // source RGB for the pack, RGB, grey and HSV paths
  always_comb begin
    case (conversion_mode)
      pcsc_pkg::MODE_565_TO_RGB, pcsc_pkg::MODE_565_TO_GREY,
      pcsc_pkg::MODE_565_TO_HSV: begin
        src.r = {s1_pix.primary_in[15:11], s1_pix.primary_in[15:13]};
        src.g = {s1_pix.primary_in[10:5], s1_pix.primary_in[10:9]};
        src.b = {s1_pix.primary_in[4:0], s1_pix.primary_in[4:2]};
      end
      pcsc_pkg::MODE_GREY_TO_RGB, pcsc_pkg::MODE_GREY_TO_565: begin
        src = {s1_pix.primary_in[7:0], s1_pix.primary_in[7:0], s1_pix.primary_in[7:0]};
      end
      default: begin
        src = {s1_pix.primary_in[7:0], s1_pix.second_in, s1_pix.third_in};
      end
    endcase
    lsum = {10'd0, src.r} * 18'd306 + {10'd0, src.g} * 18'd601
         + {10'd0, src.b} * 18'd117;
  end

  pcsc_rgb2hsv u_rgb2hsv (
    .clk (clk),
    .pix (src),
    .hsv (hsv_res)
  );

  pcsc_hsv2rgb u_hsv2rgb (
    .clk (clk),
    .hue (s1_pix.primary_in),
    .sat (s1_pix.second_in),
    .val (s1_pix.third_in),
    .rgb (rgb_res)
  );

  // side line for the short paths, aligned with the converter stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DEPTH-2:0], s1_valid};
    end
    line[0] <= '{mode: conversion_mode, src: src, lsum: lsum};
    for (int k = 1; k < DEPTH; k++) begin
      line[k] <= line[k-1];
    end
  end

  always_comb begin
    res_next = '0;
    case (line[DEPTH-1].mode)
      pcsc_pkg::MODE_RGB_TO_565, pcsc_pkg::MODE_GREY_TO_565: begin
        res_next.primary_out = pack565(line[DEPTH-1].src);
      end
      pcsc_pkg::MODE_565_TO_RGB, pcsc_pkg::MODE_GREY_TO_RGB: begin
        res_next.primary_out = {8'd0, line[DEPTH-1].src.r};
        res_next.second_out = line[DEPTH-1].src.g;
        res_next.third_out = line[DEPTH-1].src.b;
      end
      pcsc_pkg::MODE_RGB_TO_GREY, pcsc_pkg::MODE_565_TO_GREY: begin
        res_next.primary_out = {8'd0, line[DEPTH-1].lsum[17:10]};
      end
      pcsc_pkg::MODE_RGB_TO_HSV, pcsc_pkg::MODE_565_TO_HSV: begin
        res_next.primary_out = {7'd0, hsv_res.h};
        res_next.second_out = hsv_res.s;
        res_next.third_out = hsv_res.v;
      end
      pcsc_pkg::MODE_HSV_TO_RGB: begin
        res_next.primary_out = {8'd0, rgb_res.r};
        res_next.second_out = rgb_res.g;
        res_next.third_out = rgb_res.b;
      end
      pcsc_pkg::MODE_HSV_TO_565: begin
        res_next.primary_out = pack565(rgb_res);
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[DEPTH-1];
    end
    result <= res_next;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##9 done)
    else $error("item accepted but no result after fixed latency");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##9 !done)
    else $error("result strobe without an accepted item");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    (vld[DEPTH-1] && (line[DEPTH-1].mode == pcsc_pkg::MODE_RGB_TO_HSV ||
                      line[DEPTH-1].mode == pcsc_pkg::MODE_565_TO_HSV))
    |=> (result.primary_out < 16'd360))
    else $error("hue out of range");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    (vld[DEPTH-1] && (line[DEPTH-1].mode == pcsc_pkg::MODE_RGB_TO_565 ||
                      line[DEPTH-1].mode == pcsc_pkg::MODE_RGB_TO_GREY ||
                      line[DEPTH-1].mode == pcsc_pkg::MODE_565_TO_GREY ||
                      line[DEPTH-1].mode == pcsc_pkg::MODE_GREY_TO_565 ||
                      line[DEPTH-1].mode == pcsc_pkg::MODE_HSV_TO_565))
    |=> (result.second_out == 8'd0 && result.third_out == 8'd0))
    else $error("unused output fields not zero");
`endif

endmodule

/* sim/tb_pixel_color_space_converter.sv */
module tb_pixel_color_space_converter;
  import pcsc_pkg::*;

  localparam logic [3:0] MODE_UNUSED_LO = 4'd10;
  localparam logic [3:0] MODE_UNUSED_HI = 4'd15;
  localparam int RANDOM_PIXELS = 1300;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [3:0] mode;
    pix_in_t    pix;
    bit         typed;
    pix_out_t   want;
  } stim_row_t;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  pix_in_t  pixel;
  logic     done;
  pix_out_t result;
  logic     cfg_we;
  logic [3:0] cfg_data;

  pix_out_t   expected_colors[$];
  stim_row_t  directed_rows[$];
  logic [3:0] active_mode;
  bit         gaps_on;
  int         pixels_sent;
  int         results_checked;
  int         bad_results;
  int         mode_writes;
  int         mode_hits[16];
  pix_out_t   head_want;

  pixel_color_space_converter uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .pixel    (pixel),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic rgb_t expand565(logic [15:0] word);
    rgb_t c;
    c.r = {word[15:11], word[15:13]};
    c.g = {word[10:5], word[10:9]};
    c.b = {word[4:0], word[4:2]};
    return c;
  endfunction

  function automatic logic [15:0] pack565(rgb_t c);
    return {c.r[7:3], c.g[7:2], c.b[7:3]};
  endfunction

  function automatic logic [7:0] luma(rgb_t c);
    int unsigned sum;
    sum = 306 * int'(c.r) + 601 * int'(c.g) + 117 * int'(c.b);
    return sum[17:10];
  endfunction

  function automatic hsv_t rgb_to_hsv(rgb_t c);
    int r;
    int g;
    int b;
    int mx;
    int mn;
    int spread;
    int hue;
    hsv_t o;
    r = c.r;
    g = c.g;
    b = c.b;
    mx = (r > g) ? r : g;
    mn = (r < g) ? r : g;
    if (b > mx) mx = b;
    if (b < mn) mn = b;
    o = '0;
    o.v = mx[7:0];
    if (mx == 0 || mx == mn) return o;
    spread = mx - mn;
    o.s = 8'((255 * spread) / mx);
    // red wins ties over green, green over blue; division truncates toward zero
    if (r == mx) hue = ((g - b) * 60) / spread;
    else if (g == mx) hue = 120 + ((b - r) * 60) / spread;
    else hue = 240 + ((r - g) * 60) / spread;
    if (hue < 0) hue += 360;
    o.h = 9'(hue);
    return o;
  endfunction

  function automatic rgb_t hsv_to_rgb(logic [15:0] hue_raw, logic [7:0] sat, logic [7:0] val);
    int unsigned h;
    int unsigned s;
    int unsigned v;
    int unsigned sector;
    int unsigned frac;
    int unsigned p;
    int unsigned q;
    int unsigned t;
    rgb_t c;
    s = sat;
    v = val;
    if (s == 0) return rgb_t'{val, val, val};
    h = hue_raw % 360;
    sector = h / 60;
    frac = ((h % 60) * 255) / 60;
    p = (v * (255 - s)) / 255;
    q = (v * (65025 - s * frac)) / 65025;
    t = (v * (65025 - s * (255 - frac))) / 65025;
    case (sector)
      0: c = rgb_t'{8'(v), 8'(t), 8'(p)};
      1: c = rgb_t'{8'(q), 8'(v), 8'(p)};
      2: c = rgb_t'{8'(p), 8'(v), 8'(t)};
      3: c = rgb_t'{8'(p), 8'(q), 8'(v)};
      4: c = rgb_t'{8'(t), 8'(p), 8'(v)};
      default: c = rgb_t'{8'(v), 8'(p), 8'(q)};
    endcase
    return c;
  endfunction

  function automatic pix_out_t convert_pixel(logic [3:0] mode, pix_in_t p);
    pix_out_t o;
    rgb_t c;
    hsv_t hv;
    logic [7:0] lo;
    o = '0;
    lo = p.primary_in[7:0];
    case (mode)
      MODE_RGB_TO_565: o.primary_out = pack565(rgb_t'{lo, p.second_in, p.third_in});
      MODE_565_TO_RGB: begin
        c = expand565(p.primary_in);
        o = pix_out_t'{{8'h00, c.r}, c.g, c.b};
      end
      MODE_RGB_TO_GREY: o.primary_out = {8'h00, luma(rgb_t'{lo, p.second_in, p.third_in})};
      MODE_GREY_TO_RGB: o = pix_out_t'{{8'h00, lo}, lo, lo};
      MODE_565_TO_GREY: o.primary_out = {8'h00, luma(expand565(p.primary_in))};
      MODE_GREY_TO_565: o.primary_out = pack565(rgb_t'{lo, lo, lo});
      MODE_RGB_TO_HSV: begin
        hv = rgb_to_hsv(rgb_t'{lo, p.second_in, p.third_in});
        o = pix_out_t'{{7'h00, hv.h}, hv.s, hv.v};
      end
      MODE_HSV_TO_RGB: begin
        c = hsv_to_rgb(p.primary_in, p.second_in, p.third_in);
        o = pix_out_t'{{8'h00, c.r}, c.g, c.b};
      end
      MODE_565_TO_HSV: begin
        hv = rgb_to_hsv(expand565(p.primary_in));
        o = pix_out_t'{{7'h00, hv.h}, hv.s, hv.v};
      end
      MODE_HSV_TO_565: o.primary_out = pack565(hsv_to_rgb(p.primary_in, p.second_in, p.third_in));
      default: o = '0;
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic pix_in_t random_pixel(logic [3:0] mode);
    pix_in_t p;
    p.primary_in = 16'($urandom_range(16'hFFFF));
    p.second_in = 8'($urandom_range(8'hFF));
    p.third_in = 8'($urandom_range(8'hFF));
    case (mode)
      MODE_RGB_TO_HSV: begin
        // steer toward ties, greys and a zero red channel
        case ($urandom_range(7))
          0: p.second_in = p.primary_in[7:0];
          1: p.third_in = p.second_in;
          2: p.third_in = p.primary_in[7:0];
          3: begin
            p.second_in = p.primary_in[7:0];
            p.third_in = p.primary_in[7:0];
          end
          4: p.primary_in[7:0] = 8'h00;
          default: ;
        endcase
      end
      MODE_HSV_TO_RGB, MODE_HSV_TO_565: begin
        if ($urandom_range(3) != 0) p.primary_in = 16'($urandom_range(359));
        if ($urandom_range(9) == 0) p.second_in = 8'h00;
      end
      MODE_565_TO_HSV: begin
        if ($urandom_range(3) == 0) p.primary_in[4:0] = p.primary_in[15:11];
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic add_row(input logic [3:0] m, input logic [15:0] a, input logic [7:0] b,
                         input logic [7:0] c, input bit typed, input logic [15:0] wa,
                         input logic [7:0] wb, input logic [7:0] wc);
    stim_row_t row;
    row.mode = m;
    row.pix = pix_in_t'{a, b, c};
    row.typed = typed;
    row.want = pix_out_t'{wa, wb, wc};
    directed_rows.push_back(row);
  endtask

  task automatic send_pixel(input pix_in_t p, input pix_out_t want);
    while (gaps_on && $urandom_range(99) < 19) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_colors.push_back(want);
    pixels_sent++;
    mode_hits[active_mode]++;
  endtask

  // mode is only changed once every pending pixel has come back
  task automatic change_mode(input logic [3:0] m);
    start <= 1'b0;
    @(posedge clk);
    while (expected_colors.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_mode = m;
    mode_writes++;
  endtask

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    if (!rst && done) begin
      results_checked++;
      if (expected_colors.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("ERROR: unexpected result %h/%h/%h", result.primary_out,
                   result.second_out, result.third_out);
      end else begin
        head_want = expected_colors.pop_front();
        if (result.primary_out !== head_want.primary_out ||
            result.second_out !== head_want.second_out ||
            result.third_out !== head_want.third_out) begin
          bad_results++;
          if (bad_results <= 10)
            $display("ERROR: result %0d expected %h/%h/%h got %h/%h/%h", results_checked,
                     head_want.primary_out, head_want.second_out, head_want.third_out,
                     result.primary_out, result.second_out, result.third_out);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int random_sent;
    int run_len;
    int modes_seen;
    logic [3:0] next_mode;
    pix_in_t p;

    rst = 1'b1;
    start = 1'b0;
    pixel = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    active_mode = MODE_RGB_TO_565;
    gaps_on = 1'b1;
    pixels_sent = 0;
    results_checked = 0;
    bad_results = 0;
    mode_writes = 0;
    random_sent = 0;
    foreach (mode_hits[i]) mode_hits[i] = 0;

    // first rows run on the reset mode
    add_row(MODE_RGB_TO_565, 16'hFFFF, 8'hFF, 8'hFF, 1, 16'hFFFF, 8'h00, 8'h00);
    add_row(MODE_RGB_TO_565, 16'hAB00, 8'h00, 8'h00, 1, 16'h0000, 8'h00, 8'h00);
    add_row(MODE_565_TO_RGB, 16'hFFFF, 8'h00, 8'h00, 1, 16'h00FF, 8'hFF, 8'hFF);
    add_row(MODE_565_TO_RGB, 16'hF800, 8'hFF, 8'hFF, 1, 16'h00FF, 8'h00, 8'h00);
    add_row(MODE_RGB_TO_GREY, 16'hFFFF, 8'hFF, 8'hFF, 1, 16'h00FF, 8'h00, 8'h00);
    add_row(MODE_RGB_TO_GREY, 16'h1280, 8'h40, 8'h90, 0, '0, '0, '0);
    add_row(MODE_GREY_TO_RGB, 16'hFF7F, 8'hAA, 8'h55, 1, 16'h007F, 8'h7F, 8'h7F);
    add_row(MODE_565_TO_GREY, 16'hFFFF, 8'h00, 8'h00, 1, 16'h00FF, 8'h00, 8'h00);
    add_row(MODE_565_TO_GREY, 16'h07E0, 8'hAA, 8'h55, 0, '0, '0, '0);
    add_row(MODE_GREY_TO_565, 16'h01FF, 8'h12, 8'h34, 1, 16'hFFFF, 8'h00, 8'h00);
    add_row(MODE_RGB_TO_HSV, 16'h0000, 8'h00, 8'h00, 1, 16'h0000, 8'h00, 8'h00);
    add_row(MODE_RGB_TO_HSV, 16'hFF80, 8'h80, 8'h80, 1, 16'h0000, 8'h00, 8'h80);
    add_row(MODE_RGB_TO_HSV, 16'h00FF, 8'h00, 8'h00, 1, 16'h0000, 8'hFF, 8'hFF);
    add_row(MODE_RGB_TO_HSV, 16'h00FF, 8'hFF, 8'h00, 0, '0, '0, '0);
    add_row(MODE_RGB_TO_HSV, 16'h00FF, 8'h00, 8'h10, 0, '0, '0, '0);
    add_row(MODE_RGB_TO_HSV, 16'h0000, 8'hFF, 8'hFF, 0, '0, '0, '0);
    add_row(MODE_HSV_TO_RGB, 16'd200, 8'h00, 8'h77, 1, 16'h0077, 8'h77, 8'h77);
    add_row(MODE_HSV_TO_RGB, 16'hFFFF, 8'hFF, 8'hFF, 0, '0, '0, '0);
    add_row(MODE_HSV_TO_RGB, 16'd359, 8'hFF, 8'h80, 0, '0, '0, '0);
    add_row(MODE_565_TO_HSV, 16'hFFFF, 8'h00, 8'h00, 1, 16'h0000, 8'h00, 8'hFF);
    add_row(MODE_565_TO_HSV, 16'hF800, 8'h00, 8'h00, 1, 16'h0000, 8'hFF, 8'hFF);
    add_row(MODE_HSV_TO_565, 16'd0, 8'h00, 8'hFF, 1, 16'hFFFF, 8'h00, 8'h00);
    add_row(MODE_HSV_TO_565, 16'd1000, 8'h80, 8'hC0, 0, '0, '0, '0);
    add_row(MODE_UNUSED_LO, 16'h1234, 8'h56, 8'h78, 1, 16'h0000, 8'h00, 8'h00);
    add_row(MODE_UNUSED_HI, 16'hFFFF, 8'hFF, 8'hFF, 1, 16'h0000, 8'h00, 8'h00);
    add_row(MODE_RGB_TO_565, 16'h00F8, 8'hFC, 8'hF8, 1, 16'hFFFF, 8'h00, 8'h00);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].mode != active_mode) change_mode(directed_rows[i].mode);
      send_pixel(directed_rows[i].pix, directed_rows[i].typed ? directed_rows[i].want :
                 convert_pixel(active_mode, directed_rows[i].pix));
    end

    // runs of random length per mode; unknown modes now and then
    while (random_sent < RANDOM_PIXELS) begin
      if ($urandom_range(9) == 0) next_mode = 4'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
      else next_mode = 4'($urandom_range(MODE_HSV_TO_565, MODE_RGB_TO_565));
      if (next_mode != active_mode) change_mode(next_mode);
      run_len = $urandom_range(60, 10);
      repeat (run_len) begin
        gaps_on = !(random_sent >= 500 && random_sent < 800);
        p = random_pixel(active_mode);
        send_pixel(p, convert_pixel(active_mode, p));
        random_sent++;
      end
    end

    start <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    modes_seen = 0;
    foreach (mode_hits[i]) if (mode_hits[i] != 0) modes_seen++;
    $display("Converted %0d pixels, %0d results checked, %0d bad", pixels_sent,
             results_checked, bad_results);
    $display("%0d of 16 mode codes exercised over %0d mode register writes", modes_seen,
             mode_writes);
    if (bad_results == 0 && expected_colors.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/pcsc_pkg.sv
rtl/pcsc_rgb2hsv.sv
rtl/pcsc_hsv2rgb.sv
rtl/pixel_color_space_converter.sv
sim/tb_pixel_color_space_converter.sv
